>>> hw/rtl/rmf_pkg.sv
// Shared definitions for the recursive lock with a waiting queue.
// Holds default sizes, action codes and status codes; depends on nothing.
`timescale 1ns / 1ps

package rmf_pkg;

   localparam int DEF_ID_WIDTH    = 8;
   localparam int DEF_COUNT_WIDTH = 16;
   localparam int DEF_QUEUE_DEPTH = 16;

   localparam int STATUS_WIDTH = 4;
   localparam int ACTION_WIDTH = 2;

   // Only the high bit of the action selects unlock.
   localparam logic [ACTION_WIDTH-1:0] ACT_LOCK     = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_TRY_LOCK = 2'd1;
   localparam int                      ACT_UNLOCK_BIT = 1;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_ACQUIRED   = 4'd0,
      ST_QUEUED     = 4'd1,
      ST_BUSY       = 4'd2,
      ST_RELEASED   = 4'd3,
      ST_FREED      = 4'd4,
      ST_HANDED     = 4'd5,
      ST_OVERFLOW   = 4'd6,
      ST_NOT_OWNER  = 4'd7,
      ST_QUEUE_FULL = 4'd8
   } status_type;

endpackage

>>> hw/rtl/rmf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the waiting queue; depends on nothing.
`timescale 1ns / 1ps

module rmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/recursive_mutex_fifo_handoff.sv
// Top level of the recursive lock: owner, recursion count and request sequencer.
// Depends on rmf_pkg and on rmf_ram, which holds the queue of waiters.
`timescale 1ns / 1ps
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  action, requester_id
//  rsp      out        rsp_valid / rsp_ready  status, wake, owner, depth, waiters
//
//  Each request passes two states: S_IDLE captures it and reads the queue head
//  from the RAM, S_EXEC decides and writes back; the registered read needs this.
//  A new request is taken while an earlier beat still waits on rsp; the
//  decision cycle stalls only while that beat has not been taken.
//  Synchronous reset frees the lock and empties the queue; no clearing pass.

module recursive_mutex_fifo_handoff
   import rmf_pkg::*;
#(
   parameter int ID_WIDTH    = DEF_ID_WIDTH,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int FW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ACTION_WIDTH-1:0] req_action,
   input  logic [ID_WIDTH-1:0]     req_requester_id,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_WIDTH-1:0] rsp_status,
   output logic                    rsp_wake_valid,
   output logic [ID_WIDTH-1:0]     rsp_wake_id,
   output logic                    rsp_held,
   output logic [ID_WIDTH-1:0]     rsp_current_owner,
   output logic [COUNT_WIDTH-1:0]  rsp_depth_now,
   output logic [FW-1:0]           rsp_waiters_now
);

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type               state_ff, state_in;
   logic [ACTION_WIDTH-1:0] act_ff, act_in;
   logic [ID_WIDTH-1:0]     who_ff, who_in;

   logic                    owner_valid_ff, owner_valid_in;
   logic [ID_WIDTH-1:0]     owner_id_ff, owner_id_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [QW-1:0]           head_ff, head_in;
   logic [QW-1:0]           tail_ff, tail_in;
   logic [FW-1:0]           fill_ff, fill_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              status_ff, status_in;
   logic                    wake_valid_ff, wake_valid_in;
   logic [ID_WIDTH-1:0]     wake_id_ff, wake_id_in;

   logic                    accept;
   logic                    fire;
   logic                    push;
   logic [ID_WIDTH-1:0]     head_data;
   logic                    is_owner;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign fire      = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign is_owner  = owner_valid_ff && (owner_id_ff == who_ff);

   function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] p);
      logic [QW-1:0] r;
      r = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   // The head is read when a request is captured; writes only happen in the
   // decision cycle, so a read and a write never meet on the same entry.
   rmf_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (who_ff),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (head_data)
   );

   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      who_in         = who_ff;
      owner_valid_in = owner_valid_ff;
      owner_id_in    = owner_id_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      status_in      = status_ff;
      wake_valid_in  = wake_valid_ff;
      wake_id_in     = wake_id_ff;
      push           = 1'b0;

      if (accept) begin
         act_in   = req_action;
         who_in   = req_requester_id;
         state_in = S_EXEC;
      end

      if (fire) begin
         state_in      = S_IDLE;
         rsp_valid_in  = 1'b1;
         wake_valid_in = 1'b0;
         wake_id_in    = '0;
         if (act_ff[ACT_UNLOCK_BIT]) begin
            if (!is_owner) begin
               status_in = ST_NOT_OWNER;
            end else if (count_ff > COUNT_WIDTH'(1)) begin
               count_in  = count_ff - 1'b1;
               status_in = ST_RELEASED;
            end else if (fill_ff == '0) begin
               owner_valid_in = 1'b0;
               owner_id_in    = '0;
               count_in       = '0;
               status_in      = ST_FREED;
            end else begin
               owner_id_in   = head_data;
               count_in      = COUNT_WIDTH'(1);
               head_in       = next_slot(head_ff);
               fill_in       = fill_ff - 1'b1;
               wake_valid_in = 1'b1;
               wake_id_in    = head_data;
               status_in     = ST_HANDED;
            end
         end else if (!owner_valid_ff) begin
            owner_valid_in = 1'b1;
            owner_id_in    = who_ff;
            count_in       = COUNT_WIDTH'(1);
            status_in      = ST_ACQUIRED;
         end else if (is_owner) begin
            if (count_ff == '1) begin
               status_in = ST_OVERFLOW;
            end else begin
               count_in  = count_ff + 1'b1;
               status_in = ST_ACQUIRED;
            end
         end else if (act_ff == ACT_TRY_LOCK) begin
            status_in = ST_BUSY;
         end else if (fill_ff == FW'(QUEUE_DEPTH)) begin
            status_in = ST_QUEUE_FULL;
         end else begin
            push      = 1'b1;
            tail_in   = next_slot(tail_ff);
            fill_in   = fill_ff + 1'b1;
            status_in = ST_QUEUED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         owner_valid_ff <= 1'b0;
         owner_id_ff    <= '0;
         count_ff       <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         fill_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         owner_valid_ff <= owner_valid_in;
         owner_id_ff    <= owner_id_in;
         count_ff       <= count_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         fill_ff        <= fill_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      act_ff        <= act_in;
      who_ff        <= who_in;
      status_ff     <= status_in;
      wake_valid_ff <= wake_valid_in;
      wake_id_ff    <= wake_id_in;
   end

   // The result beat reflects the lock state written by the same decision.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_wake_valid    = wake_valid_ff;
   assign rsp_wake_id       = wake_id_ff;
   assign rsp_held          = owner_valid_ff;
   assign rsp_current_owner = owner_valid_ff ? owner_id_ff : '0;
   assign rsp_depth_now     = count_ff;
   assign rsp_waiters_now   = fill_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   a_wake_handed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wake_valid |-> rsp_status == ST_HANDED)
      else $error("wake without hand-off");

   a_free_clean: assert property (@(posedge clock) disable iff (reset)
      !owner_valid_ff |-> count_ff == '0 && owner_id_ff == '0)
      else $error("free lock keeps owner or count");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second request taken before decision");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(fill_ff) && $stable(head_ff) && $stable(tail_ff))
      else $error("queue moved outside a decision");

endmodule
